>>> rtl/bfsc_pkg.sv
package bfsc_pkg;

	// Geometry of the entry store
	localparam int DEPTH     = 64;
	localparam int KEY_BITS  = 16;
	localparam int DATA_BITS = 32;
	localparam int PTR_W     = $clog2(DEPTH);
	localparam int CNT_W     = PTR_W + 1;
	localparam int ENTRY_W   = KEY_BITS + DATA_BITS;

	// Field widths fixed by the interface
	localparam int OP_W   = 3;
	localparam int STAT_W = 2;
	localparam int CAP_W  = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUT    = 3'd0;
	localparam logic [OP_W-1:0] OP_GET    = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
	localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
	localparam logic [OP_W-1:0] OP_NEXT   = 3'd4;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NONE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_DROP = 2'd2;

	typedef struct packed {
		logic [KEY_BITS-1:0]  entry_key;
		logic [DATA_BITS-1:0] entry_data;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PUT,
		ST_GET,
		ST_NEXT,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

endpackage

>>> rtl/bfsc_ram.sv
module bfsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, register one read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/bounded_fifo_with_search_and_cursor.sv
// Bounded FIFO of key/data entries with key search and a round-robin cursor.
// Input channel: in_valid/in_stall carries operation, key_in, data_in; a beat
// is taken when in_valid is high and in_stall is low. Output channel:
// out_valid/out_stall carries status, key_out, data_out, entry_count; each
// input beat gives exactly one output beat, in order.
// Config channel: cfg_valid/cfg_ready writes capacity_limit from cfg_data;
// write it only while no operation is in flight. Zero or above DEPTH means
// DEPTH entries.
// Timing: a beat is taken in the idle state only, so one operation is in
// flight at a time and the next beat is taken in the cycle after the result
// loads. Put without a drop, unknown codes and any lookup on an empty queue
// go from the exec state straight to done; get, next and put with a drop
// add one entry read. Find scans the single read port of the entry RAM one
// entry a cycle. Remove adds a shift pass that moves one entry a cycle
// through that same port.
// Reset clears the pointers, count, cursor and output valid and sets the
// limit to 64; the entry RAM is not cleared. While the receiver stalls, the
// output register holds its beat; one more operation can be accepted and
// completed, then it waits until the output register frees up.
module bounded_fifo_with_search_and_cursor (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bfsc_pkg::OP_W-1:0]           operation,
	input  logic [bfsc_pkg::KEY_BITS-1:0]       key_in,
	input  logic [bfsc_pkg::DATA_BITS-1:0]      data_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bfsc_pkg::STAT_W-1:0]         status,
	output logic [bfsc_pkg::KEY_BITS-1:0]       key_out,
	output logic [bfsc_pkg::DATA_BITS-1:0]      data_out,
	output logic [bfsc_pkg::CNT_W-1:0]          entry_count,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bfsc_pkg::CAP_W-1:0]          cfg_data
);

	localparam int PW = bfsc_pkg::PTR_W;
	localparam int CW = bfsc_pkg::CNT_W;

	bfsc_pkg::state_t state_q, state_d;

	logic [bfsc_pkg::OP_W-1:0]      op_q;
	logic [bfsc_pkg::KEY_BITS-1:0]  key_q;
	logic [bfsc_pkg::DATA_BITS-1:0] data_q;
	logic [bfsc_pkg::CAP_W-1:0]     cap_q;
	logic [PW-1:0]                  head_q;
	logic [CW-1:0]                  occ_q;
	logic [PW-1:0]                  cur_q;
	logic [CW-1:0]                  iss_q;
	logic [PW-1:0]                  pos_q;
	logic                           chk_vld_s1;
	logic [PW-1:0]                  chk_idx_s1;

	logic [bfsc_pkg::STAT_W-1:0]    res_status_q;
	logic [bfsc_pkg::KEY_BITS-1:0]  res_key_q;
	logic [bfsc_pkg::DATA_BITS-1:0] res_data_q;

	logic                           out_valid_q;
	logic [bfsc_pkg::STAT_W-1:0]    out_status_q;
	logic [bfsc_pkg::KEY_BITS-1:0]  out_key_q;
	logic [bfsc_pkg::DATA_BITS-1:0] out_data_q;
	logic [CW-1:0]                  out_count_q;

	logic                           ram_we, ram_re;
	logic [PW-1:0]                  ram_waddr, ram_raddr;
	logic [bfsc_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
	bfsc_pkg::entry_t               rd_entry, new_entry;

	logic [CW-1:0] eff_lim;
	logic          drop;
	logic [PW-1:0] cur_sel;
	logic          hit, last_chk, has_next;
	logic          out_load, out_take;
	logic          rm_commit;
	logic [PW-1:0] rm_pos;
	logic [CW-1:0] occ_m1;
	logic [PW-1:0] pop_cur;

	// Effective limit and derived conditions
	always_comb begin
		if (cap_q == '0 || int'(cap_q) > bfsc_pkg::DEPTH) begin
			eff_lim = CW'(bfsc_pkg::DEPTH);
		end else begin
			eff_lim = CW'(cap_q);
		end
	end

	assign drop      = occ_q >= eff_lim;
	assign occ_m1    = occ_q - CW'(1);
	assign cur_sel   = ({1'b0, cur_q} >= occ_q) ? '0 : cur_q;
	assign pop_cur   = (occ_q == CW'(1) || cur_q == '0) ? '0 : cur_q - PW'(1);
	assign rd_entry  = bfsc_pkg::entry_t'(ram_rdata);
	assign new_entry = '{entry_key: key_q, entry_data: data_q};
	assign hit       = chk_vld_s1 && rd_entry.entry_key == key_q;
	assign last_chk  = chk_vld_s1 && {1'b0, chk_idx_s1} == occ_m1;
	assign has_next  = ({1'b0, chk_idx_s1} + CW'(1)) < occ_q;
	assign out_take  = out_valid_q && !out_stall;
	assign out_load  = (state_q == bfsc_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	// Commit a removal once the gap is closed
	always_comb begin
		rm_commit = 1'b0;
		rm_pos    = pos_q;
		if (state_q == bfsc_pkg::ST_SCAN && hit && op_q == bfsc_pkg::OP_REMOVE && !has_next) begin
			rm_commit = 1'b1;
			rm_pos    = chk_idx_s1;
		end else if (state_q == bfsc_pkg::ST_SHIFT && iss_q >= occ_q && !chk_vld_s1) begin
			rm_commit = 1'b1;
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfsc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM control
	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		ram_we    = 1'b0;
		ram_waddr = head_q + occ_q[PW-1:0];
		ram_wdata = new_entry;
		unique case (state_q)
			bfsc_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = bfsc_pkg::ST_EXEC;
				end
			end
			bfsc_pkg::ST_EXEC: begin
				unique case (op_q)
					bfsc_pkg::OP_PUT: begin
						if (drop) begin
							ram_re  = 1'b1;
							state_d = bfsc_pkg::ST_PUT;
						end else begin
							ram_we  = 1'b1;
							state_d = bfsc_pkg::ST_DONE;
						end
					end
					bfsc_pkg::OP_GET: begin
						if (occ_q == '0) begin
							state_d = bfsc_pkg::ST_DONE;
						end else begin
							ram_re  = 1'b1;
							state_d = bfsc_pkg::ST_GET;
						end
					end
					bfsc_pkg::OP_NEXT: begin
						if (occ_q == '0) begin
							state_d = bfsc_pkg::ST_DONE;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = head_q + cur_sel;
							state_d   = bfsc_pkg::ST_NEXT;
						end
					end
					bfsc_pkg::OP_REMOVE, bfsc_pkg::OP_FIND: begin
						state_d = (occ_q == '0) ? bfsc_pkg::ST_DONE : bfsc_pkg::ST_SCAN;
					end
					default: begin
						state_d = bfsc_pkg::ST_DONE;
					end
				endcase
			end
			bfsc_pkg::ST_PUT: begin
				ram_we  = 1'b1;
				state_d = bfsc_pkg::ST_DONE;
			end
			bfsc_pkg::ST_GET, bfsc_pkg::ST_NEXT: begin
				state_d = bfsc_pkg::ST_DONE;
			end
			bfsc_pkg::ST_SCAN: begin
				if (hit) begin
					if (op_q == bfsc_pkg::OP_REMOVE && has_next) begin
						state_d = bfsc_pkg::ST_SHIFT;
					end else begin
						state_d = bfsc_pkg::ST_DONE;
					end
				end else if (last_chk) begin
					state_d = bfsc_pkg::ST_DONE;
				end else if (iss_q < occ_q) begin
					ram_re    = 1'b1;
					ram_raddr = head_q + iss_q[PW-1:0];
				end
			end
			bfsc_pkg::ST_SHIFT: begin
				// Write back the entry read last cycle one slot lower
				if (chk_vld_s1) begin
					ram_we    = 1'b1;
					ram_waddr = head_q + chk_idx_s1;
					ram_wdata = ram_rdata;
				end
				if (iss_q < occ_q) begin
					ram_re    = 1'b1;
					ram_raddr = head_q + iss_q[PW-1:0];
				end else if (!chk_vld_s1) begin
					state_d = bfsc_pkg::ST_DONE;
				end
			end
			bfsc_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = bfsc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bfsc_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers: pointers, count, cursor, limit, pipeline valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= bfsc_pkg::CAP_RESET;
			head_q     <= '0;
			occ_q      <= '0;
			cur_q      <= '0;
			chk_vld_s1 <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			chk_vld_s1 <= 1'b0;
			unique case (state_q)
				bfsc_pkg::ST_EXEC: begin
					if (op_q == bfsc_pkg::OP_PUT && !drop) begin
						if (occ_q == '0) begin
							cur_q <= '0;
						end
						occ_q <= occ_q + CW'(1);
					end
					if (op_q == bfsc_pkg::OP_NEXT) begin
						cur_q <= cur_sel;
					end
				end
				bfsc_pkg::ST_PUT: begin
					head_q <= head_q + PW'(1);
					cur_q  <= pop_cur;
				end
				bfsc_pkg::ST_GET: begin
					head_q <= head_q + PW'(1);
					occ_q  <= occ_m1;
					cur_q  <= pop_cur;
				end
				bfsc_pkg::ST_NEXT: begin
					cur_q <= ({1'b0, cur_q} + CW'(1) < occ_q) ? cur_q + PW'(1) : '0;
				end
				bfsc_pkg::ST_SCAN, bfsc_pkg::ST_SHIFT: begin
					chk_vld_s1 <= ram_re && !(state_q == bfsc_pkg::ST_SCAN && hit);
				end
				default: begin
				end
			endcase
			// Close the gap: count drops, cursor follows
			if (rm_commit) begin
				occ_q <= occ_m1;
				if (occ_m1 == '0) begin
					cur_q <= '0;
				end else if (cur_q > rm_pos) begin
					cur_q <= cur_q - PW'(1);
				end else if (cur_q == rm_pos && {1'b0, rm_pos} >= occ_m1) begin
					cur_q <= '0;
				end
			end
		end
	end

	// Item capture, scan counters and pending result
	always_ff @(posedge clk) begin
		unique case (state_q)
			bfsc_pkg::ST_IDLE: begin
				if (in_valid) begin
					op_q   <= operation;
					key_q  <= key_in;
					data_q <= data_in;
				end
			end
			bfsc_pkg::ST_EXEC: begin
				iss_q        <= '0;
				res_status_q <= (op_q == bfsc_pkg::OP_PUT) ? bfsc_pkg::STAT_OK : bfsc_pkg::STAT_NONE;
				res_key_q    <= '0;
				res_data_q   <= '0;
			end
			bfsc_pkg::ST_PUT: begin
				res_status_q <= bfsc_pkg::STAT_DROP;
				res_key_q    <= rd_entry.entry_key;
				res_data_q   <= rd_entry.entry_data;
			end
			bfsc_pkg::ST_GET, bfsc_pkg::ST_NEXT: begin
				res_status_q <= bfsc_pkg::STAT_OK;
				res_key_q    <= rd_entry.entry_key;
				res_data_q   <= rd_entry.entry_data;
			end
			bfsc_pkg::ST_SCAN: begin
				if (hit) begin
					res_status_q <= bfsc_pkg::STAT_OK;
					res_key_q    <= rd_entry.entry_key;
					res_data_q   <= rd_entry.entry_data;
					pos_q        <= chk_idx_s1;
					iss_q        <= {1'b0, chk_idx_s1} + CW'(1);
				end else if (ram_re) begin
					chk_idx_s1 <= iss_q[PW-1:0];
					iss_q      <= iss_q + CW'(1);
				end
			end
			bfsc_pkg::ST_SHIFT: begin
				if (ram_re) begin
					chk_idx_s1 <= iss_q[PW-1:0] - PW'(1);
					iss_q      <= iss_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: hold while stalled, load when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_key_q    <= res_key_q;
			out_data_q   <= res_data_q;
			out_count_q  <= occ_q;
		end
	end

	bfsc_ram #(
		.WIDTH(bfsc_pkg::ENTRY_W),
		.DEPTH(bfsc_pkg::DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_stall    = state_q != bfsc_pkg::ST_IDLE;
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign key_out     = out_key_q;
	assign data_out    = out_data_q;
	assign entry_count = out_count_q;

endmodule

>>> rtl/bfsc_checker.sv
module bfsc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [bfsc_pkg::STAT_W-1:0]         status,
	input logic [bfsc_pkg::KEY_BITS-1:0]       key_out,
	input logic [bfsc_pkg::DATA_BITS-1:0]      data_out,
	input logic [bfsc_pkg::CNT_W-1:0]          entry_count
);

	// Count never exceeds the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> int'(entry_count) <= bfsc_pkg::DEPTH)
		else $error("entry_count above depth");

	// A miss or empty result carries no entry
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bfsc_pkg::STAT_NONE |-> key_out == '0 && data_out == '0)
		else $error("miss result with nonzero payload");

	// Only defined status codes appear
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == bfsc_pkg::STAT_OK || status == bfsc_pkg::STAT_NONE ||
			status == bfsc_pkg::STAT_DROP)
		else $error("undefined status code");

	// One operation in flight: accept closes the input
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second beat accepted back to back");

	// A stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(key_out) &&
			$stable(data_out) && $stable(entry_count))
		else $error("stalled output beat changed");

endmodule

bind bounded_fifo_with_search_and_cursor bfsc_checker u_bfsc_checker (.*);

>>> tb/sv/bounded_fifo_with_search_and_cursor_tb.sv
module bounded_fifo_with_search_and_cursor_tb;

	import bfsc_pkg::*;

	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 7;
	localparam int LONG_HOLD      = 400;
	localparam int TIMEOUT_CYCLES = 2_000_000;
	localparam int RECENT_KEYS    = 24;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_ITEMS    = 103;

	// Codes past the last defined operation; the block answers them as no-ops
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic [KEY_BITS-1:0]  key;
		logic [DATA_BITS-1:0] data;
	} fifo_op_t;

	typedef struct packed {
		logic [STAT_W-1:0]    status;
		logic [KEY_BITS-1:0]  key;
		logic [DATA_BITS-1:0] data;
		logic [CNT_W-1:0]     count;
	} fifo_result_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic [OP_W-1:0]      operation   = '0;
	logic [KEY_BITS-1:0]  key_in      = '0;
	logic [DATA_BITS-1:0] data_in     = '0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic [STAT_W-1:0]    status;
	logic [KEY_BITS-1:0]  key_out;
	logic [DATA_BITS-1:0] data_out;
	logic [CNT_W-1:0]     entry_count;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CAP_W-1:0]     cfg_data    = '0;

	// Stimulus and scoreboard storage
	fifo_op_t             ops_to_send[$];
	fifo_result_t         answers_due[$];
	logic [KEY_BITS-1:0]  recent_keys[$];
	fifo_op_t             taken_op;
	fifo_result_t         oldest_answer;

	int beats_offered = 0;
	int beats_taken   = 0;
	int gap_left      = 0;
	int stall_left    = 0;
	int idle_on       = 1;
	int hold_req      = 0;
	int hold_seen     = 0;
	int fail_count    = 0;

	// Shadow copy of the entry store, pointers and limit
	logic [KEY_BITS-1:0]  shadow_keys [DEPTH];
	logic [DATA_BITS-1:0] shadow_data [DEPTH];
	int                   shadow_head   = 0;
	int                   shadow_fill   = 0;
	int                   shadow_cursor = 0;
	logic [CAP_W-1:0]     shadow_cap    = CAP_RESET;

	bounded_fifo_with_search_and_cursor dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.key_in      (key_in),
		.data_in     (data_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.key_out     (key_out),
		.data_out    (data_out),
		.entry_count (entry_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Pop the oldest shadow entry and pull the cursor back with it
	function automatic void pop_oldest(output logic [KEY_BITS-1:0] k,
			output logic [DATA_BITS-1:0] d);
		k = shadow_keys[shadow_head];
		d = shadow_data[shadow_head];
		shadow_head = (shadow_head + 1) % DEPTH;
		shadow_fill--;
		if (shadow_cursor > 0)
			shadow_cursor--;
		if (shadow_fill == 0)
			shadow_cursor = 0;
	endfunction

	// Apply one operation to the shadow FIFO and return its answer
	function automatic fifo_result_t apply_fifo_op(input fifo_op_t item);
		fifo_result_t res;
		int limit;
		int pos;
		int i;
		res.status = STAT_NONE;
		res.key    = '0;
		res.data   = '0;
		limit = (shadow_cap == 0 || shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
		case (item.op)
			OP_PUT: begin
				res.status = STAT_OK;
				if (shadow_fill + 1 > limit) begin
					pop_oldest(res.key, res.data);
					res.status = STAT_DROP;
				end
				if (shadow_fill == 0)
					shadow_cursor = 0;
				pos = (shadow_head + shadow_fill) % DEPTH;
				shadow_keys[pos] = item.key;
				shadow_data[pos] = item.data;
				shadow_fill++;
			end
			OP_GET: begin
				if (shadow_fill > 0) begin
					pop_oldest(res.key, res.data);
					res.status = STAT_OK;
				end
			end
			OP_REMOVE, OP_FIND: begin
				// Scan backward so the oldest match wins
				pos = shadow_fill;
				for (i = shadow_fill - 1; i >= 0; i--)
					if (shadow_keys[(shadow_head + i) % DEPTH] == item.key)
						pos = i;
				if (pos < shadow_fill) begin
					res.status = STAT_OK;
					res.key    = shadow_keys[(shadow_head + pos) % DEPTH];
					res.data   = shadow_data[(shadow_head + pos) % DEPTH];
					if (item.op == OP_REMOVE) begin
						// Close the gap and move the cursor with the entries
						for (i = pos; i + 1 < shadow_fill; i++) begin
							shadow_keys[(shadow_head + i) % DEPTH] =
								shadow_keys[(shadow_head + i + 1) % DEPTH];
							shadow_data[(shadow_head + i) % DEPTH] =
								shadow_data[(shadow_head + i + 1) % DEPTH];
						end
						shadow_fill--;
						if (shadow_cursor > pos)
							shadow_cursor--;
						else if (shadow_cursor == pos && pos >= shadow_fill)
							shadow_cursor = 0;
						if (shadow_fill == 0)
							shadow_cursor = 0;
					end
				end
			end
			OP_NEXT: begin
				if (shadow_fill > 0) begin
					if (shadow_cursor >= shadow_fill)
						shadow_cursor = 0;
					pos = (shadow_head + shadow_cursor) % DEPTH;
					res.status = STAT_OK;
					res.key    = shadow_keys[pos];
					res.data   = shadow_data[pos];
					shadow_cursor = (shadow_cursor + 1 < shadow_fill) ? shadow_cursor + 1 : 0;
				end
			end
			default: begin
			end
		endcase
		res.count = CNT_W'(shadow_fill);
		return res;
	endfunction

	// Mostly short pauses, now and then a long one
	function automatic int idle_span();
		if ($urandom_range(0, 99) < 88)
			return $urandom_range(1, 3);
		return $urandom_range(15, 50);
	endfunction

	task automatic queue_op(input logic [OP_W-1:0] op, input logic [KEY_BITS-1:0] k,
			input logic [DATA_BITS-1:0] d);
		fifo_op_t item;
		item.op   = op;
		item.key  = k;
		item.data = d;
		ops_to_send.push_back(item);
	endtask

	// Random traffic: keys drawn mostly from a small pool so searches hit
	task automatic queue_random_ops(input int count, input int put_share);
		int n;
		int roll;
		int sel;
		logic [OP_W-1:0]     op;
		logic [KEY_BITS-1:0] k;
		for (n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < put_share) begin
				op = OP_PUT;
			end else begin
				sel = $urandom_range(0, 99);
				if (sel < 20)
					op = OP_GET;
				else if (sel < 45)
					op = OP_REMOVE;
				else if (sel < 72)
					op = OP_FIND;
				else if (sel < 96)
					op = OP_NEXT;
				else
					op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
			end
			sel = $urandom_range(0, 99);
			if (recent_keys.size() != 0 && sel < ((op == OP_PUT) ? 15 : 70))
				k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
			else if (sel % 3 == 0)
				k = KEY_BITS'($urandom);
			else
				k = KEY_BITS'($urandom_range(0, 15));
			if (op == OP_PUT) begin
				recent_keys.push_back(k);
				if (recent_keys.size() > RECENT_KEYS)
					void'(recent_keys.pop_front());
			end
			queue_op(op, k, $urandom);
		end
	endtask

	// Wait until every queued operation has been answered
	task automatic drain();
		while (ops_to_send.size() != 0 || in_valid || answers_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the capacity limit while the block is idle
	task automatic write_limit(input logic [CAP_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		shadow_cap = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drive input beats; hold each until it is taken, then pause at random
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && beats_taken != beats_offered) begin
				in_valid <= 1'b1;
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (ops_to_send.size() != 0) begin
				taken_op  = ops_to_send.pop_front();
				operation <= taken_op.op;
				key_in    <= taken_op.key;
				data_in   <= taken_op.data;
				in_valid  <= 1'b1;
				beats_offered <= beats_offered + 1;
				gap_left  <= (idle_on == 0 || $urandom_range(0, 99) < 55) ? 0 : idle_span();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Predict the answer of each accepted beat
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			answers_due.push_back(apply_fifo_op({operation, key_in, data_in}));
			beats_taken <= beats_taken + 1;
		end
	end

	// Stall the output side: random pauses plus a requested long hold-off
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen  <= hold_req;
			stall_left <= LONG_HOLD - 1;
			out_stall  <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (idle_on != 0 && $urandom_range(0, 99) < 30) begin
			stall_left <= idle_span() - 1;
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Check each output beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (answers_due.size() == 0) begin
				$error("output beat with no prediction pending: status %0d key %0h data %0h",
					status, key_out, data_out);
				fail_count++;
			end else begin
				oldest_answer = answers_due.pop_front();
				if (status !== oldest_answer.status) begin
					$error("status: expected %0d, got %0d", oldest_answer.status, status);
					fail_count++;
				end
				if (key_out !== oldest_answer.key) begin
					$error("key_out: expected %0h, got %0h", oldest_answer.key, key_out);
					fail_count++;
				end
				if (data_out !== oldest_answer.data) begin
					$error("data_out: expected %0h, got %0h", oldest_answer.data, data_out);
					fail_count++;
				end
				if (entry_count !== oldest_answer.count) begin
					$error("entry_count: expected %0d, got %0d", oldest_answer.count,
						entry_count);
					fail_count++;
				end
			end
		end
	end

	// Main sequence: reset, directed cases, then random phases
	initial begin
		logic [CAP_W-1:0] cap_plan [RANDOM_PHASES];
		int               put_plan [RANDOM_PHASES];
		int               p;
		cap_plan = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd7, 7'd100, 7'd64, 7'd2, 7'd33, 7'd64};
		put_plan = '{65, 45, 50, 40, 45, 55, 45, 50, 40, 35};
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty queue: every lookup misses
		queue_op(OP_GET, 16'h0005, 32'h0);
		queue_op(OP_FIND, 16'h0005, 32'h0);
		queue_op(OP_REMOVE, 16'h0005, 32'h0);
		queue_op(OP_NEXT, 16'h0005, 32'h0);
		// Extreme fields, hits and misses
		queue_op(OP_PUT, 16'hFFFF, 32'hFFFF_FFFF);
		queue_op(OP_PUT, 16'h0000, 32'h0000_0000);
		queue_op(OP_PUT, 16'h1234, 32'hA5A5_5A5A);
		queue_op(OP_FIND, 16'h1234, 32'hFFFF_FFFF);
		queue_op(OP_FIND, 16'h7777, 32'h0);
		queue_op(OP_REMOVE, 16'h7777, 32'h0);
		// Walk the cursor past the end and back to the head
		queue_op(OP_NEXT, 16'h0, 32'h0);
		queue_op(OP_NEXT, 16'h0, 32'h0);
		queue_op(OP_NEXT, 16'h0, 32'h0);
		queue_op(OP_NEXT, 16'h0, 32'h0);
		// Remove the entry under the cursor
		queue_op(OP_REMOVE, 16'h0000, 32'h0);
		queue_op(OP_NEXT, 16'h0, 32'h0);
		// Unused operation codes
		queue_op(OP_SPARE_LO, 16'hFFFF, 32'hFFFF_FFFF);
		queue_op(OP_W'(OP_SPARE_LO + 3'd1), 16'h0, 32'h0);
		queue_op(OP_SPARE_HI, 16'h1234, 32'h1);
		queue_op(OP_GET, 16'h0, 32'h0);
		drain();

		// Full queue at a small limit drops the oldest
		write_limit(7'd2);
		queue_op(OP_PUT, 16'h0101, 32'h1111_1111);
		queue_op(OP_PUT, 16'h0202, 32'h2222_2222);
		queue_op(OP_PUT, 16'h0303, 32'h3333_3333);
		drain();

		// Limit lowered below the count: one drop, count unchanged
		write_limit(7'd64);
		queue_op(OP_PUT, 16'h0404, 32'h4444_4444);
		queue_op(OP_PUT, 16'h0505, 32'h5555_5555);
		queue_op(OP_PUT, 16'h0606, 32'h6666_6666);
		drain();
		write_limit(7'd3);
		queue_op(OP_PUT, 16'h0707, 32'h7777_7777);
		drain();

		// Random phases over several limits, zero and out-of-range among them
		for (p = 0; p < RANDOM_PHASES; p++) begin
			write_limit(cap_plan[p]);
			idle_on = (p == 3 || p == 6) ? 0 : 1;
			queue_random_ops(PHASE_ITEMS, put_plan[p]);
			// Back up the output while the sender keeps offering
			if (p == 6)
				hold_req++;
			drain();
		end
		idle_on = 1;

		repeat (2 * DEPTH + 20) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("simulation failed");
		$finish;
	end

endmodule
